### hdl/wbs_pkg.sv
// Shared types and constants for the weight bin selector.
`default_nettype none

package wbs_pkg;

    localparam int AREA_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int DIST_W   = 17;
    localparam int ENTRY_W  = 2 * WEIGHT_W;

    localparam logic KIND_REG    = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    localparam logic STRAT_RANGE = 1'b0;
    localparam logic STRAT_SEQ   = 1'b1;

    typedef enum logic [1:0] {
        METHOD_RANGE   = 2'd0,
        METHOD_CLOSEST = 2'd1,
        METHOD_SEQ     = 2'd2,
        METHOD_NONE    = 2'd3
    } t_method;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                kind;
        logic [AREA_W-1:0]   area_id;
        logic [WEIGHT_W-1:0] range_low;
        logic [WEIGHT_W-1:0] range_high;
        logic [TAG_W-1:0]    object_tag;
        logic [WEIGHT_W-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]    object_out;
        logic [WEIGHT_W-1:0] weight_out;
        logic [AREA_W-1:0]   area_out;
        t_method             method;
    } t_out_item;

endpackage

`default_nettype wire

### hdl/wbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### hdl/weight_bin_selector.sv
// Top level of the weight bin selector: area table, scan sequencer, output register.
// Register transaction: writes the area table, gives no result; the input stays ready.
// Weight transaction, range mode: the scan reads one table entry per cycle through the
//   table RAM read port; no new input is taken until the result is registered.
// Weight transaction, sequential mode: the result passes the done state into the output register;
//   a stalled result holds off input. Reset clears strategy, valid bits, count, pointer.
`default_nettype none

module weight_bin_selector
    import wbs_pkg::*;
#(
    parameter int AREA_SLOTS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data
);

    localparam int IDX_W = $clog2(AREA_SLOTS);
    localparam logic [IDX_W:0]   SLOTS_C = (IDX_W + 1)'(AREA_SLOTS);
    localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(AREA_SLOTS - 1);

    t_state r_state, n_state;

    logic                  r_strategy;
    logic [AREA_SLOTS-1:0] r_valid, n_valid;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [AREA_W-1:0]     r_rr, n_rr;

    logic [TAG_W-1:0]      r_tag, n_tag;
    logic [WEIGHT_W-1:0]   r_w, n_w;

    logic [IDX_W:0]        r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;

    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_match_id, n_match_id;
    logic                  r_have, n_have;
    logic [DIST_W-1:0]     r_best, n_best;
    logic [IDX_W-1:0]      r_best_id, n_best_id;

    logic [AREA_W-1:0]     r_res_area, n_res_area;
    t_method               r_res_method, n_res_method;

    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_fire;
    logic                  id_ok;
    logic [IDX_W-1:0]      wr_addr;
    logic                  ram_wr_en;
    logic [ENTRY_W-1:0]    ram_rd_data;
    logic [WEIGHT_W-1:0]   ent_low;
    logic [WEIGHT_W-1:0]   ent_high;
    logic                  ent_valid;
    logic                  in_range;
    logic [DIST_W-1:0]     ent_sum;
    logic [DIST_W-1:0]     w_dbl;
    logic [DIST_W-1:0]     ent_dist;
    logic                  seq_ok;
    logic                  scan_end;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign id_ok     = 32'(i_in_data.area_id) < 32'(AREA_SLOTS);
    assign wr_addr   = IDX_W'(i_in_data.area_id);
    assign ram_wr_en = in_fire && (i_in_data.kind == KIND_REG) && id_ok;

    wbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (AREA_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_in_data.range_high, i_in_data.range_low}),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign ent_low   = ram_rd_data[WEIGHT_W-1:0];
    assign ent_high  = ram_rd_data[ENTRY_W-1:WEIGHT_W];
    assign ent_valid = r_rd_vld && r_valid[r_rd_idx];
    assign in_range  = (r_w >= ent_low) && (r_w <= ent_high);
    assign ent_sum   = {1'b0, ent_low} + {1'b0, ent_high};
    assign w_dbl     = {r_w, 1'b0};
    assign ent_dist  = (w_dbl >= ent_sum) ? (w_dbl - ent_sum) : (ent_sum - w_dbl);
    assign scan_end  = r_rd_vld && (r_rd_idx == LAST_C);

    always_comb begin
        seq_ok = 1'b0;
        for (int i = 0; i < AREA_SLOTS; i++) begin
            if (i == int'(r_rr)) begin
                seq_ok = r_valid[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in_data.kind == KIND_WEIGHT) && (r_count != '0)) begin
                    n_state = (r_strategy == STRAT_SEQ) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_valid      = r_valid;
        n_count      = r_count;
        n_rr         = r_rr;
        n_tag        = r_tag;
        n_w          = r_w;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_match_id   = r_match_id;
        n_have       = r_have;
        n_best       = r_best;
        n_best_id    = r_best_id;
        n_res_area   = r_res_area;
        n_res_method = r_res_method;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (ram_wr_en && !r_valid[wr_addr]) begin
                    n_valid[wr_addr] = 1'b1;
                    n_count          = r_count + 1'b1;
                end
                if (in_fire && (i_in_data.kind == KIND_WEIGHT)) begin
                    n_tag   = i_in_data.object_tag;
                    n_w     = i_in_data.weight;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_have  = 1'b0;
                    if (seq_ok && (32'(r_rr) < 32'(AREA_SLOTS))) begin
                        n_res_area   = r_rr;
                        n_res_method = METHOD_SEQ;
                    end else begin
                        n_res_area   = '0;
                        n_res_method = METHOD_NONE;
                    end
                    if (in_fire && (r_strategy == STRAT_SEQ) && (r_count != '0) &&
                        (n_res_method == METHOD_SEQ)) begin
                        n_rr = (COUNT_W'(r_rr) + 1'b1 == r_count) ? '0 : r_rr + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx < SLOTS_C) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                    n_idx    = r_idx + 1'b1;
                end
                if (ent_valid && !r_found && in_range) begin
                    n_found    = 1'b1;
                    n_match_id = r_rd_idx;
                end
                if (ent_valid && (!r_have || (ent_dist < r_best))) begin
                    n_have    = 1'b1;
                    n_best    = ent_dist;
                    n_best_id = r_rd_idx;
                end
                if (scan_end) begin
                    if (n_found) begin
                        n_res_area   = AREA_W'(n_match_id);
                        n_res_method = METHOD_RANGE;
                    end else begin
                        n_res_area   = AREA_W'(n_best_id);
                        n_res_method = METHOD_CLOSEST;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.object_out = r_tag;
                    n_out.weight_out = r_w;
                    n_out.area_out   = r_res_area;
                    n_out.method     = r_res_method;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_strategy  <= STRAT_RANGE;
            r_valid     <= '0;
            r_count     <= '0;
            r_rr        <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_strategy <= i_cfg_data;
            end
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_rr        <= n_rr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag        <= n_tag;
        r_w          <= n_w;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_found      <= n_found;
        r_match_id   <= n_match_id;
        r_have       <= n_have;
        r_best       <= n_best;
        r_best_id    <= n_best_id;
        r_res_area   <= n_res_area;
        r_res_method <= n_res_method;
        r_out        <= n_out;
    end

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_valid))
        else $error("entry count disagrees with valid bits");

    a_pointer_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (COUNT_W'(r_rr) < r_count))
        else $error("round robin pointer at or beyond entry count");

    a_empty_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_data.kind == KIND_WEIGHT) && (r_count == '0))
        |=> (r_state == ST_IDLE))
        else $error("weight transaction on empty table started work");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside of done state");

endmodule

`default_nettype wire
